// ===== sv/anim_seq_pkg.sv =====
package anim_seq_pkg;

   localparam int MAX_STEPS = 64;
   localparam int MAX_WALK  = 256;

   localparam int STEP_W = $clog2(MAX_STEPS);
   localparam int CNT_W  = STEP_W + 1;
   localparam int CAND_W = STEP_W + 2;
   localparam int WALK_W = $clog2(MAX_WALK);

   localparam int OP_W       = 3;
   localparam int IDX_W      = 7;
   localparam int TV_W       = 17;
   localparam int DUR_W      = 16;
   localparam int TIME_W     = 24;
   localparam int ANS_W      = 25;
   localparam int WT_W       = 19;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int CFG_CNT_W  = 7;
   localparam int CFG_LS_W   = 6;

   localparam logic [DUR_W-1:0]  HOLD_CODE = 16'hFFFF;
   localparam logic [DUR_W-1:0]  DUR_MAX   = 16'hFFFE;
   localparam logic [DUR_W-1:0]  SAT16     = 16'hFFFF;
   localparam logic [TIME_W-1:0] SAT24     = 24'hFFFFFF;

   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_PAUSE   = 3'd1;
   localparam logic [OP_W-1:0] OP_UNPAUSE = 3'd2;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd4;
   localparam logic [OP_W-1:0] OP_SINCE   = 3'd5;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_START = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL      = 2'd2;

   localparam logic [1:0] RD_CUR  = 2'd0;
   localparam logic [1:0] RD_SUM  = 2'd1;
   localparam logic [1:0] RD_WALK = 2'd2;

   localparam logic [1:0] SUM_RESTART = 2'd0;
   localparam logic [1:0] SUM_SINCE   = 2'd1;
   localparam logic [1:0] SUM_WRAP    = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       wr_dur;
      logic [1:0] rd_src;
      logic       pause_set;
      logic       pause_clr;
      logic       tick_apply;
      logic       sum_init;
      logic [1:0] sum_src;
      logic       sum_acc;
      logic       load_step;
      logic       set_since;
      logic       walk_fwd_init;
      logic       walk_bwd_init;
      logic       walk_eval;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic paused;
      logic tick_wrap;
      logic sum_done;
      logic req_tv_pos;
      logic rd_hold;
      logic walk_hit;
      logic walk_last;
   } status_type;

endpackage

// ===== sv/anim_seq_ctrl.sv =====
module anim_seq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [anim_seq_pkg::OP_W-1:0]  req_opcode,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output anim_seq_pkg::cmd_type          cmd,
   input  anim_seq_pkg::status_type       status
);
   import anim_seq_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_TICK    = 3'd1;
   localparam logic [2:0] S_SUM_RD  = 3'd2;
   localparam logic [2:0] S_SUM_ACC = 3'd3;
   localparam logic [2:0] S_WB      = 3'd4;
   localparam logic [2:0] S_WALK_RD = 3'd5;
   localparam logic [2:0] S_WALK_EV = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       since_ff, since_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      cmd.rd_src = RD_CUR;
      state_in = state_ff;
      since_in = since_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DONE;
               case (req_opcode)
                  OP_TICK: begin
                     if (!status.paused) state_in = S_TICK;
                  end
                  OP_PAUSE:   cmd.pause_set = 1'b1;
                  OP_UNPAUSE: cmd.pause_clr = 1'b1;
                  OP_RESTART: begin
                     cmd.sum_init = 1'b1;
                     cmd.sum_src  = SUM_RESTART;
                     since_in     = 1'b0;
                     state_in     = S_SUM_RD;
                  end
                  OP_WRITE: cmd.wr_dur = 1'b1;
                  OP_SINCE: begin
                     cmd.sum_init = 1'b1;
                     cmd.sum_src  = SUM_SINCE;
                     since_in     = 1'b1;
                     state_in     = S_SUM_RD;
                  end
                  OP_LOOKUP: begin
                     if (status.req_tv_pos) begin
                        cmd.walk_fwd_init = 1'b1;
                        state_in          = S_WALK_RD;
                     end else begin
                        state_in = S_WB;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_TICK: begin
            cmd.tick_apply = 1'b1;
            if (status.tick_wrap) begin
               // past the last step: rebuild overall time from the loop target
               cmd.sum_init = 1'b1;
               cmd.sum_src  = SUM_WRAP;
               since_in     = 1'b0;
               state_in     = S_SUM_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SUM_RD: begin
            if (status.sum_done) begin
               if (since_ff) cmd.set_since = 1'b1;
               else          cmd.load_step = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_src = RD_SUM;
               state_in   = S_SUM_ACC;
            end
         end
         S_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in    = S_SUM_RD;
         end
         S_WB: begin
            cmd.walk_bwd_init = 1'b1;
            state_in = status.rd_hold ? S_DONE : S_WALK_RD;
         end
         S_WALK_RD: begin
            cmd.rd_src = RD_WALK;
            state_in   = S_WALK_EV;
         end
         S_WALK_EV: begin
            cmd.walk_eval = 1'b1;
            state_in = (status.walk_hit || status.walk_last) ? S_DONE : S_WALK_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)    rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         since_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/anim_seq_dp.sv =====
module anim_seq_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  anim_seq_pkg::cmd_type                  cmd,
   output anim_seq_pkg::status_type               status,
   input  logic                                   csr_wr_en,
   input  logic [anim_seq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [anim_seq_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  logic [anim_seq_pkg::IDX_W-1:0]         req_step_index,
   input  logic signed [anim_seq_pkg::TV_W-1:0]   req_time_value,
   output logic [anim_seq_pkg::IDX_W-1:0]         rsp_current_step,
   output logic [anim_seq_pkg::DUR_W-1:0]         rsp_step_ticks,
   output logic [anim_seq_pkg::TIME_W-1:0]        rsp_elapsed_ticks,
   output logic [anim_seq_pkg::TIME_W-1:0]        rsp_remaining_ticks,
   output logic                                   rsp_step_starting,
   output logic                                   rsp_is_paused,
   output logic signed [anim_seq_pkg::ANS_W-1:0]  rsp_query_answer,
   output logic                                   rsp_walk_failed
);
   import anim_seq_pkg::*;

   // configuration
   logic [CFG_CNT_W-1:0] step_count_ff, step_count_in;
   logic [CFG_LS_W-1:0]  loop_start_ff, loop_start_in;
   logic [TIME_W-1:0]    total_ff, total_in;

   // playback state
   logic [STEP_W-1:0] pos_ff, pos_in;
   logic [DUR_W-1:0]  ts_ff, ts_in;
   logic [TIME_W-1:0] ov_ff, ov_in;
   logic              paused_ff, paused_in;

   // duration memory
   logic [DUR_W-1:0]  dur_mem [MAX_STEPS];
   logic [DUR_W-1:0]  rd_data_ff;
   logic [STEP_W-1:0] rd_addr;
   logic [DUR_W-1:0]  wr_val;
   logic              wr_ok;

   // working registers
   logic signed [TV_W-1:0]  tv_ff, tv_in;
   logic [TIME_W-1:0]       sum_ff, sum_in;
   logic [STEP_W-1:0]       k_ff, k_in;
   logic [STEP_W-1:0]       i_ff, i_in;
   logic [STEP_W-1:0]       c_ff, c_in;
   logic signed [WT_W-1:0]  t_ff, t_in;
   logic [WALK_W-1:0]       it_ff, it_in;
   logic                    bwd_ff, bwd_in;
   logic signed [ANS_W-1:0] ans_ff, ans_in;
   logic                    failed_ff, failed_in;

   // result register
   logic [IDX_W-1:0]        o_step_ff;
   logic [DUR_W-1:0]        o_ts_ff;
   logic [TIME_W-1:0]       o_ov_ff;
   logic [TIME_W-1:0]       o_rem_ff;
   logic                    o_start_ff;
   logic                    o_paused_ff;
   logic signed [ANS_W-1:0] o_ans_ff;
   logic                    o_failed_ff;

   // derived values
   logic [CNT_W-1:0]        n;
   logic [STEP_W-1:0]       n_m1;
   logic [STEP_W-1:0]       lt;
   logic [STEP_W-1:0]       cur;
   logic [CNT_W-1:0]        cur_nxt;
   logic [TIME_W-1:0]       ov_inc;
   logic [DUR_W-1:0]        ts_inc;
   logic                    tick_adv;
   logic                    rd_hold;
   logic [DUR_W-1:0]        d_add;
   logic [TIME_W:0]         sum_wide;
   logic signed [WT_W-1:0]  d_t;
   logic signed [WT_W-1:0]  tv_req_ext;
   logic signed [WT_W-1:0]  tv_ff_ext;
   logic signed [WT_W-1:0]  ts_ext;
   logic [CAND_W-1:0]       cand_u;
   logic signed [CAND_W-1:0] cand;
   logic [STEP_W-1:0]       c_nxt;
   logic                    walk_hit;
   logic                    walk_last;
   logic signed [ANS_W-1:0] ans_c;
   logic signed [ANS_W-1:0] ans_cur;
   logic [STEP_W-1:0]       k_restart;
   logic [STEP_W-1:0]       k_since;

   always_comb begin
      if (step_count_ff == '0)                    n = CNT_W'(1);
      else if (32'(step_count_ff) > MAX_STEPS)    n = CNT_W'(MAX_STEPS);
      else                                        n = CNT_W'(step_count_ff);
   end

   assign n_m1 = STEP_W'(n - CNT_W'(1));
   assign lt   = (32'(loop_start_ff) >= 32'(n)) ? n_m1 : STEP_W'(loop_start_ff);
   assign cur  = (32'(pos_ff) >= 32'(n)) ? n_m1 : pos_ff;

   // tick arithmetic
   assign cur_nxt  = CNT_W'(cur) + CNT_W'(1);
   assign ov_inc   = (ov_ff == SAT24) ? ov_ff : ov_ff + TIME_W'(1);
   assign ts_inc   = (ts_ff == SAT16) ? ts_ff : ts_ff + DUR_W'(1);
   assign rd_hold  = (rd_data_ff == HOLD_CODE);
   assign tick_adv = !rd_hold && (ts_inc >= rd_data_ff);

   // start time accumulation, hold steps add nothing
   assign d_add    = rd_hold ? '0 : rd_data_ff;
   assign sum_wide = {1'b0, sum_ff} + (TIME_W+1)'(d_add);

   assign k_restart = (32'(req_step_index) >= 32'(n)) ? lt : STEP_W'(req_step_index);
   always_comb begin
      if (req_step_index == '0)                                 k_since = '0;
      else if (32'(req_step_index) - 32'd1 >= 32'(n_m1))        k_since = n_m1;
      else                                                      k_since = STEP_W'(req_step_index - IDX_W'(1));
   end

   // walk arithmetic
   assign d_t        = $signed({{(WT_W-DUR_W){1'b0}}, rd_data_ff});
   assign tv_req_ext = $signed({{(WT_W-TV_W){req_time_value[TV_W-1]}}, req_time_value});
   assign tv_ff_ext  = $signed({{(WT_W-TV_W){tv_ff[TV_W-1]}}, tv_ff});
   assign ts_ext     = $signed({{(WT_W-DUR_W){1'b0}}, ts_ff});
   assign walk_hit   = rd_hold || (t_ff < d_t);
   assign walk_last  = (it_ff == WALK_W'(MAX_WALK - 1));

   assign cand_u = bwd_ff ? {2'b00, c_ff} - CAND_W'(1) : {2'b00, c_ff} + CAND_W'(1);
   assign cand   = $signed(cand_u);
   always_comb begin
      if (cand == $signed({1'b0, n}))              c_nxt = lt;
      else if (cand < $signed({2'b00, lt}))        c_nxt = n_m1;
      else                                         c_nxt = cand_u[STEP_W-1:0];
   end

   assign ans_c   = $signed(ANS_W'(c_ff) + ANS_W'(1));
   assign ans_cur = $signed(ANS_W'(cur) + ANS_W'(1));

   // duration write clamp, minus one means hold
   always_comb begin
      if (req_time_value == -17'sd1)        wr_val = HOLD_CODE;
      else if (req_time_value < 17'sd0)     wr_val = '0;
      else if (req_time_value > 17'sd65534) wr_val = DUR_MAX;
      else                                  wr_val = req_time_value[DUR_W-1:0];
   end
   assign wr_ok = (32'(req_step_index) < MAX_STEPS);

   always_comb begin
      case (cmd.rd_src)
         RD_SUM:  rd_addr = i_ff;
         RD_WALK: rd_addr = c_ff;
         default: rd_addr = cur;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_dur && wr_ok) dur_mem[STEP_W'(req_step_index)] <= wr_val;
      rd_data_ff <= dur_mem[rd_addr];
   end

   // configuration writes
   always_comb begin
      step_count_in = step_count_ff;
      loop_start_in = loop_start_ff;
      total_in      = total_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STEP_COUNT: step_count_in = csr_wr_data[CFG_CNT_W-1:0];
            CSR_LOOP_START: loop_start_in = csr_wr_data[CFG_LS_W-1:0];
            CSR_TOTAL:      total_in      = csr_wr_data[TIME_W-1:0];
            default:        total_in      = total_ff;
         endcase
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      ts_in     = ts_ff;
      ov_in     = ov_ff;
      paused_in = paused_ff;
      tv_in     = tv_ff;
      sum_in    = sum_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      c_in      = c_ff;
      t_in      = t_ff;
      it_in     = it_ff;
      bwd_in    = bwd_ff;
      ans_in    = ans_ff;
      failed_in = failed_ff;

      if (cmd.capture) begin
         tv_in     = req_time_value;
         ans_in    = '0;
         failed_in = 1'b0;
      end
      if (cmd.pause_set) paused_in = 1'b1;
      if (cmd.pause_clr) paused_in = 1'b0;

      if (cmd.tick_apply) begin
         ov_in = ov_inc;
         if (tick_adv) begin
            ts_in  = '0;
            pos_in = cur_nxt[STEP_W-1:0];
         end else begin
            ts_in = ts_inc;
         end
      end

      if (cmd.sum_init) begin
         sum_in = '0;
         i_in   = '0;
         case (cmd.sum_src)
            SUM_RESTART: k_in = k_restart;
            SUM_SINCE:   k_in = k_since;
            default:     k_in = lt;
         endcase
      end
      if (cmd.sum_acc) begin
         sum_in = (sum_wide > (TIME_W+1)'(SAT24)) ? SAT24 : sum_wide[TIME_W-1:0];
         i_in   = i_ff + STEP_W'(1);
      end
      if (cmd.load_step) begin
         pos_in = k_ff;
         ts_in  = '0;
         ov_in  = sum_ff;
      end
      if (cmd.set_since) begin
         ans_in = $signed({1'b0, ov_ff}) - $signed({1'b0, sum_ff});
      end

      if (cmd.walk_fwd_init) begin
         c_in   = cur;
         t_in   = tv_req_ext + ts_ext;
         it_in  = '0;
         bwd_in = 1'b0;
      end
      if (cmd.walk_bwd_init) begin
         // a current hold step answers itself
         if (rd_hold) begin
            ans_in = ans_cur;
         end else begin
            c_in   = cur;
            t_in   = -tv_ff_ext + d_t - WT_W'(1) - ts_ext;
            it_in  = '0;
            bwd_in = 1'b1;
         end
      end
      if (cmd.walk_eval) begin
         if (walk_hit) begin
            ans_in = ans_c;
         end else if (walk_last) begin
            failed_in = 1'b1;
         end else begin
            t_in  = t_ff - d_t;
            c_in  = c_nxt;
            it_in = it_ff + WALK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= CFG_CNT_W'(1);
         loop_start_ff <= '0;
         total_ff      <= '0;
         pos_ff        <= '0;
         ts_ff         <= '0;
         ov_ff         <= '0;
         paused_ff     <= 1'b0;
      end else begin
         step_count_ff <= step_count_in;
         loop_start_ff <= loop_start_in;
         total_ff      <= total_in;
         pos_ff        <= pos_in;
         ts_ff         <= ts_in;
         ov_ff         <= ov_in;
         paused_ff     <= paused_in;
      end
   end

   always_ff @(posedge clock) begin
      tv_ff     <= tv_in;
      sum_ff    <= sum_in;
      k_ff      <= k_in;
      i_ff      <= i_in;
      c_ff      <= c_in;
      t_ff      <= t_in;
      it_ff     <= it_in;
      bwd_ff    <= bwd_in;
      ans_ff    <= ans_in;
      failed_ff <= failed_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_step_ff   <= IDX_W'(CNT_W'(cur) + CNT_W'(1));
         o_ts_ff     <= ts_ff;
         o_ov_ff     <= ov_ff;
         o_rem_ff    <= (total_ff > ov_ff) ? total_ff - ov_ff - TIME_W'(1) : '0;
         o_start_ff  <= !paused_ff && (ts_ff == '0);
         o_paused_ff <= paused_ff;
         o_ans_ff    <= ans_ff;
         o_failed_ff <= failed_ff;
      end
   end

   assign status.paused     = paused_ff;
   assign status.tick_wrap  = tick_adv && (cur_nxt >= n);
   assign status.sum_done   = (i_ff == k_ff);
   assign status.req_tv_pos = (req_time_value > 17'sd0);
   assign status.rd_hold    = rd_hold;
   assign status.walk_hit   = walk_hit;
   assign status.walk_last  = walk_last;

   assign rsp_current_step    = o_step_ff;
   assign rsp_step_ticks      = o_ts_ff;
   assign rsp_elapsed_ticks   = o_ov_ff;
   assign rsp_remaining_ticks = o_rem_ff;
   assign rsp_step_starting   = o_start_ff;
   assign rsp_is_paused       = o_paused_ff;
   assign rsp_query_answer    = o_ans_ff;
   assign rsp_walk_failed     = o_failed_ff;

endmodule

// ===== sv/animation_step_sequencer.sv =====
// pause, unpause, write and a paused tick go straight to the response; a playing tick first passes the tick state
// restart, time-since query and tick past the last step sum the durations of the k steps before the target,
// alternating a duration read and an add through the single memory read port
// offset lookup walks w steps ahead or back, a read and an evaluation per step, w at most MAX_WALK
// one request in flight; the next is taken while the previous response waits
// synchronous reset clears position, step time, overall time, pause flag and config, step count set to one
module animation_step_sequencer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [anim_seq_pkg::OP_W-1:0]          req_opcode,
   input  logic [anim_seq_pkg::IDX_W-1:0]         req_step_index,
   input  logic signed [anim_seq_pkg::TV_W-1:0]   req_time_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [anim_seq_pkg::IDX_W-1:0]         rsp_current_step,
   output logic [anim_seq_pkg::DUR_W-1:0]         rsp_step_ticks,
   output logic [anim_seq_pkg::TIME_W-1:0]        rsp_elapsed_ticks,
   output logic [anim_seq_pkg::TIME_W-1:0]        rsp_remaining_ticks,
   output logic                                   rsp_step_starting,
   output logic                                   rsp_is_paused,
   output logic signed [anim_seq_pkg::ANS_W-1:0]  rsp_query_answer,
   output logic                                   rsp_walk_failed,
   input  logic                                   csr_wr_en,
   input  logic [anim_seq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [anim_seq_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import anim_seq_pkg::*;

   cmd_type    cmd;
   status_type status;

   anim_seq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   anim_seq_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_step_index      (req_step_index),
      .req_time_value      (req_time_value),
      .rsp_current_step    (rsp_current_step),
      .rsp_step_ticks      (rsp_step_ticks),
      .rsp_elapsed_ticks   (rsp_elapsed_ticks),
      .rsp_remaining_ticks (rsp_remaining_ticks),
      .rsp_step_starting   (rsp_step_starting),
      .rsp_is_paused       (rsp_is_paused),
      .rsp_query_answer    (rsp_query_answer),
      .rsp_walk_failed     (rsp_walk_failed)
   );

endmodule

// ===== sv/anim_seq_checker.sv =====
module anim_seq_props (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic [anim_seq_pkg::OP_W-1:0]          req_opcode,
   input logic [anim_seq_pkg::IDX_W-1:0]         req_step_index,
   input logic signed [anim_seq_pkg::TV_W-1:0]   req_time_value,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [anim_seq_pkg::IDX_W-1:0]         rsp_current_step,
   input logic [anim_seq_pkg::DUR_W-1:0]         rsp_step_ticks,
   input logic [anim_seq_pkg::TIME_W-1:0]        rsp_elapsed_ticks,
   input logic [anim_seq_pkg::TIME_W-1:0]        rsp_remaining_ticks,
   input logic                                   rsp_step_starting,
   input logic                                   rsp_is_paused,
   input logic signed [anim_seq_pkg::ANS_W-1:0]  rsp_query_answer,
   input logic                                   rsp_walk_failed,
   input logic                                   csr_wr_en,
   input logic [anim_seq_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [anim_seq_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_step)
         && $stable(rsp_elapsed_ticks) && $stable(rsp_query_answer))
      else $error("response changed while stalled");

   // step start is never flagged while paused
   a_start_vs_pause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_paused && rsp_step_starting))
      else $error("step start flagged while paused");

   // a failed walk reports no step
   a_failed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_walk_failed |-> rsp_query_answer == '0)
      else $error("failed walk with nonzero answer");

   // step number is 1-based
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_current_step != '0)
      else $error("current step reported as zero");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind animation_step_sequencer anim_seq_props u_checker (.*);
